/* sv/cgf_pkg.sv */
`default_nettype none
package cgf_pkg;

    localparam int MASS_W   = 24;
    localparam int GRAV_W   = 32;
    localparam int MINS_W   = 16;
    localparam int FORCE_W  = 24;
    localparam int OUTC_W   = 25;
    localparam int NUM_W    = GRAV_W + 2 * MASS_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_W    = ((2 * OUTC_W + 2 + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAV_CONST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FORCE  = 2'd2;

    localparam logic [GRAV_W-1:0]  GRAV_RESET  = 32'd65536;
    localparam logic [MINS_W-1:0]  MINS_RESET  = 16'd2560;
    localparam logic [FORCE_W-1:0] MAXF_RESET  = 24'd1280000;

endpackage
`default_nettype wire

/* sv/clamped_gravity_force.sv */
// Softened 2D gravity force on one body pulled toward another.
// Input channel (s_axis): one word per body pair holds both positions and both
// masses; a word is taken when tvalid and tready are both high.
// Output channel (m_axis): one word per input word, in order, holding the force
// components and the limited and floored flags.
// Configuration: a write port sets the gravitational constant, the minimum
// separation and the force ceiling; write it only while no word is in flight.
// Throughput: one word per cycle while the skid register is empty. Each word passes
// through the bit-per-stage force divider and square root that run side by side,
// then the bit-per-stage component divider.
// Reset clears all valid bits and loads the register defaults.
// When the receiver stalls, the output register holds its word and a skid
// register takes one more; the input is held off only once the skid register
// is full, and no word is lost or repeated.
`default_nettype none
module clamped_gravity_force
    import cgf_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // self_x, self_y, other_x, other_y, self_mass, other_mass, zero fill
    input  wire logic [((4*COORD_WIDTH+2*MASS_W+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // force_x, force_y, was_limited, was_floored, zero fill
    output logic [OUT_W-1:0]            o_m_axis_tdata
);

    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;
    localparam int SQB  = W + 1;
    localparam int D2W  = 2 * SQB;
    localparam int CW   = (NUM_W > D2W + 32) ? NUM_W : D2W + 32;
    localparam int NI   = (SQB > FORCE_W) ? SQB : FORCE_W;
    localparam int PW   = FORCE_W + DW;
    localparam int PM_W = 2 * MASS_W;
    localparam int PG_W = MASS_W + GRAV_W;

    logic [GRAV_W-1:0]  r_grav;
    logic [MINS_W-1:0]  r_mins;
    logic [FORCE_W-1:0] r_maxf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= GRAV_RESET;
            r_mins <= MINS_RESET;
            r_maxf <= MAXF_RESET;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                CFG_GRAV_CONST: r_grav <= i_cfg_wdata[GRAV_W-1:0];
                CFG_MIN_SEP:    r_mins <= i_cfg_wdata[MINS_W-1:0];
                CFG_MAX_FORCE:  r_maxf <= i_cfg_wdata[FORCE_W-1:0];
                default: ;
            endcase
        end
    end

    logic w_ce;
    logic r_ov, r_sv;
    logic [OUT_W-1:0] r_od, r_sd;

    assign w_ce = !r_sv;
    assign o_s_axis_tready = w_ce;

    // Stage A: offsets, magnitudes, mass product, squared minimum separation.
    logic [W-1:0]      w_sx, w_sy, w_ox, w_oy;
    logic [MASS_W-1:0] w_m1, w_m2;
    logic [DW-1:0]     w_dx, w_dy;

    assign w_sx = i_s_axis_tdata[W-1:0];
    assign w_sy = i_s_axis_tdata[2*W-1:W];
    assign w_ox = i_s_axis_tdata[3*W-1:2*W];
    assign w_oy = i_s_axis_tdata[4*W-1:3*W];
    assign w_m1 = i_s_axis_tdata[4*W+MASS_W-1:4*W];
    assign w_m2 = i_s_axis_tdata[4*W+2*MASS_W-1:4*W+MASS_W];
    assign w_dx = {w_ox[W-1], w_ox} - {w_sx[W-1], w_sx};
    assign w_dy = {w_oy[W-1], w_oy} - {w_sy[W-1], w_sy};

    logic             r_a_v, r_a_sx, r_a_sy;
    logic [DW-1:0]    r_a_adx, r_a_ady;
    logic [PM_W-1:0]  r_a_pm;
    logic [31:0]      r_a_minsq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_ce) begin
            r_a_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_a_sx    <= w_dx[DW-1];
            r_a_sy    <= w_dy[DW-1];
            r_a_adx   <= w_dx[DW-1] ? DW'(-w_dx) : w_dx;
            r_a_ady   <= w_dy[DW-1] ? DW'(-w_dy) : w_dy;
            r_a_pm    <= PM_W'(w_m1) * PM_W'(w_m2);
            r_a_minsq <= 32'(r_mins) * 32'(r_mins);
        end
    end

    // Stage B: squares and partial products of the numerator.
    logic             r_b_v, r_b_sx, r_b_sy;
    logic [DW-1:0]    r_b_adx, r_b_ady;
    logic [D2W-1:0]   r_b_sqx, r_b_sqy;
    logic [PG_W-1:0]  r_b_pgh, r_b_pgl;
    logic [31:0]      r_b_minsq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (w_ce) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_b_sx    <= r_a_sx;
            r_b_sy    <= r_a_sy;
            r_b_adx   <= r_a_adx;
            r_b_ady   <= r_a_ady;
            r_b_sqx   <= D2W'(r_a_adx) * D2W'(r_a_adx);
            r_b_sqy   <= D2W'(r_a_ady) * D2W'(r_a_ady);
            r_b_pgh   <= PG_W'(r_a_pm[PM_W-1:MASS_W]) * PG_W'(r_grav);
            r_b_pgl   <= PG_W'(r_a_pm[MASS_W-1:0]) * PG_W'(r_grav);
            r_b_minsq <= r_a_minsq;
        end
    end

    // Stage C: squared distance, numerator, floor test.
    logic             r_c_v, r_c_sx, r_c_sy, r_c_flr;
    logic [DW-1:0]    r_c_adx, r_c_ady;
    logic [D2W-1:0]   r_c_d2;
    logic [NUM_W-1:0] r_c_num;
    logic [31:0]      r_c_minsq;
    logic [D2W-1:0]   w_d2;

    assign w_d2 = r_b_sqx + r_b_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_ce) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_c_sx    <= r_b_sx;
            r_c_sy    <= r_b_sy;
            r_c_adx   <= r_b_adx;
            r_c_ady   <= r_b_ady;
            r_c_d2    <= w_d2;
            r_c_flr   <= w_d2 < D2W'(r_b_minsq);
            r_c_num   <= (NUM_W'(r_b_pgh) << MASS_W) + NUM_W'(r_b_pgl);
            r_c_minsq <= r_b_minsq;
        end
    end

    // Force divider and square root, one bit per stage each.
    logic                r_i_v    [NI+1];
    logic                r_i_sx   [NI+1];
    logic                r_i_sy   [NI+1];
    logic                r_i_lim  [NI+1];
    logic                r_i_flr  [NI+1];
    logic                r_i_zero [NI+1];
    logic [DW-1:0]       r_i_adx  [NI+1];
    logic [DW-1:0]       r_i_ady  [NI+1];
    logic [NUM_W-1:0]    r_i_rem  [NI+1];
    logic [D2W-1:0]      r_i_eff  [NI+1];
    logic [FORCE_W-1:0]  r_i_q    [NI+1];
    logic [D2W-1:0]      r_i_d2   [NI+1];
    logic [SQB-1:0]      r_i_root [NI+1];
    logic [SQB+1:0]      r_i_srem [NI+1];

    logic [D2W-1:0] w_eff;
    assign w_eff = r_c_flr ? D2W'(r_c_minsq) : r_c_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_v[0] <= 1'b0;
        end else if (w_ce) begin
            r_i_v[0] <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_i_sx[0]   <= r_c_sx;
            r_i_sy[0]   <= r_c_sy;
            r_i_adx[0]  <= r_c_adx;
            r_i_ady[0]  <= r_c_ady;
            r_i_flr[0]  <= r_c_flr;
            r_i_zero[0] <= r_c_d2 == '0;
            r_i_lim[0]  <= CW'(r_c_num) >= (CW'(w_eff) << 32);
            r_i_rem[0]  <= r_c_num;
            r_i_eff[0]  <= w_eff;
            r_i_q[0]    <= '0;
            r_i_d2[0]   <= r_c_d2;
            r_i_root[0] <= '0;
            r_i_srem[0] <= '0;
        end
    end

    for (genvar k = 0; k < NI; k++) begin : g_iter
        logic [NUM_W-1:0]   n_rem;
        logic [FORCE_W-1:0] n_q;
        logic [SQB-1:0]     n_root;
        logic [SQB+1:0]     n_srem;

        if (k < FORCE_W) begin : g_div
            localparam int B = FORCE_W - 1 - k;
            logic [CW-1:0] w_s, w_r;
            logic          w_ge;
            assign w_s  = CW'(r_i_eff[k]) << (B + 8);
            assign w_r  = CW'(r_i_rem[k]);
            assign w_ge = w_r >= w_s;
            always_comb begin
                n_q    = r_i_q[k];
                n_q[B] = w_ge;
                n_rem  = w_ge ? NUM_W'(w_r - w_s) : r_i_rem[k];
            end
        end else begin : g_div_pass
            assign n_q   = r_i_q[k];
            assign n_rem = r_i_rem[k];
        end

        if (k < SQB) begin : g_sqrt
            logic [SQB+1:0] w_in, w_trial;
            logic           w_ge;
            assign w_in    = {r_i_srem[k][SQB-1:0], r_i_d2[k][D2W-1-2*k -: 2]};
            assign w_trial = {r_i_root[k], 2'b01};
            assign w_ge    = w_in >= w_trial;
            assign n_srem  = w_ge ? (w_in - w_trial) : w_in;
            assign n_root  = {r_i_root[k][SQB-2:0], w_ge};
        end else begin : g_sqrt_pass
            assign n_srem = r_i_srem[k];
            assign n_root = r_i_root[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_i_v[k+1] <= 1'b0;
            end else if (w_ce) begin
                r_i_v[k+1] <= r_i_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_i_sx[k+1]   <= r_i_sx[k];
                r_i_sy[k+1]   <= r_i_sy[k];
                r_i_adx[k+1]  <= r_i_adx[k];
                r_i_ady[k+1]  <= r_i_ady[k];
                r_i_flr[k+1]  <= r_i_flr[k];
                r_i_zero[k+1] <= r_i_zero[k];
                r_i_lim[k+1]  <= r_i_lim[k];
                r_i_rem[k+1]  <= n_rem;
                r_i_eff[k+1]  <= r_i_eff[k];
                r_i_q[k+1]    <= n_q;
                r_i_d2[k+1]   <= r_i_d2[k];
                r_i_root[k+1] <= n_root;
                r_i_srem[k+1] <= n_srem;
            end
        end
    end

    // Stage E: clamp to the ceiling.
    logic               r_e_v, r_e_sx, r_e_sy, r_e_lim, r_e_flr, r_e_zero;
    logic [DW-1:0]      r_e_adx, r_e_ady;
    logic [SQB-1:0]     r_e_dist;
    logic [FORCE_W-1:0] r_e_f;
    logic               w_over;

    assign w_over = r_i_lim[NI] || (r_i_q[NI] > r_maxf);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (w_ce) begin
            r_e_v <= r_i_v[NI];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_e_sx   <= r_i_sx[NI];
            r_e_sy   <= r_i_sy[NI];
            r_e_adx  <= r_i_adx[NI];
            r_e_ady  <= r_i_ady[NI];
            r_e_flr  <= r_i_flr[NI];
            r_e_zero <= r_i_zero[NI];
            r_e_dist <= r_i_root[NI];
            r_e_lim  <= w_over;
            r_e_f    <= w_over ? r_maxf : r_i_q[NI];
        end
    end

    // Component divider, one bit per stage.
    logic             r_f_v    [FORCE_W+1];
    logic             r_f_sx   [FORCE_W+1];
    logic             r_f_sy   [FORCE_W+1];
    logic             r_f_lim  [FORCE_W+1];
    logic             r_f_flr  [FORCE_W+1];
    logic             r_f_zero [FORCE_W+1];
    logic [SQB-1:0]   r_f_dist [FORCE_W+1];
    logic [PW-1:0]    r_f_rx   [FORCE_W+1];
    logic [PW-1:0]    r_f_ry   [FORCE_W+1];
    logic [FORCE_W-1:0] r_f_qx [FORCE_W+1];
    logic [FORCE_W-1:0] r_f_qy [FORCE_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v[0] <= 1'b0;
        end else if (w_ce) begin
            r_f_v[0] <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_f_sx[0]   <= r_e_sx;
            r_f_sy[0]   <= r_e_sy;
            r_f_lim[0]  <= r_e_lim;
            r_f_flr[0]  <= r_e_flr;
            r_f_zero[0] <= r_e_zero;
            r_f_dist[0] <= r_e_dist;
            r_f_rx[0]   <= PW'(r_e_f) * PW'(r_e_adx);
            r_f_ry[0]   <= PW'(r_e_f) * PW'(r_e_ady);
            r_f_qx[0]   <= '0;
            r_f_qy[0]   <= '0;
        end
    end

    for (genvar k = 0; k < FORCE_W; k++) begin : g_comp
        localparam int B = FORCE_W - 1 - k;
        logic [PW-1:0]      w_s;
        logic               w_gx, w_gy;
        logic [FORCE_W-1:0] n_qx, n_qy;

        assign w_s  = PW'(r_f_dist[k]) << B;
        assign w_gx = r_f_rx[k] >= w_s;
        assign w_gy = r_f_ry[k] >= w_s;

        always_comb begin
            n_qx    = r_f_qx[k];
            n_qx[B] = w_gx;
            n_qy    = r_f_qy[k];
            n_qy[B] = w_gy;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_f_v[k+1] <= 1'b0;
            end else if (w_ce) begin
                r_f_v[k+1] <= r_f_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_f_sx[k+1]   <= r_f_sx[k];
                r_f_sy[k+1]   <= r_f_sy[k];
                r_f_lim[k+1]  <= r_f_lim[k];
                r_f_flr[k+1]  <= r_f_flr[k];
                r_f_zero[k+1] <= r_f_zero[k];
                r_f_dist[k+1] <= r_f_dist[k];
                r_f_rx[k+1]   <= w_gx ? (r_f_rx[k] - w_s) : r_f_rx[k];
                r_f_ry[k+1]   <= w_gy ? (r_f_ry[k] - w_s) : r_f_ry[k];
                r_f_qx[k+1]   <= n_qx;
                r_f_qy[k+1]   <= n_qy;
            end
        end
    end

    // Sign, coincidence and packing.
    logic [OUTC_W-1:0] w_mx, w_my, w_fx, w_fy;
    logic              w_lim;
    logic [OUT_W-1:0]  w_pd;
    logic              w_pv;

    assign w_mx  = {1'b0, r_f_qx[FORCE_W]};
    assign w_my  = {1'b0, r_f_qy[FORCE_W]};
    assign w_fx  = r_f_zero[FORCE_W] ? '0 : (r_f_sx[FORCE_W] ? OUTC_W'(-w_mx) : w_mx);
    assign w_fy  = r_f_zero[FORCE_W] ? '0 : (r_f_sy[FORCE_W] ? OUTC_W'(-w_my) : w_my);
    assign w_lim = r_f_lim[FORCE_W] && !r_f_zero[FORCE_W];
    assign w_pd  = OUT_W'({r_f_flr[FORCE_W], w_lim, w_fy, w_fx});
    assign w_pv  = r_f_v[FORCE_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (i_m_axis_tready) begin
                r_ov <= 1'b1;
                r_od <= r_sd;
                r_sv <= 1'b0;
            end
        end else if (!r_ov || i_m_axis_tready) begin
            r_ov <= w_pv;
            r_od <= w_pd;
        end else if (w_pv) begin
            r_sv <= 1'b1;
            r_sd <= w_pd;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_od;

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import cgf_pkg::*;

    localparam int CW     = 24;
    localparam int IN_W   = ((4 * CW + 2 * MASS_W + 7) / 8) * 8;
    localparam int LAT    = 56;
    localparam int NRAND  = 1750;
    localparam int WD_MAX = 4000;

    typedef struct packed {
        logic signed [OUTC_W-1:0] fx;
        logic signed [OUTC_W-1:0] fy;
        logic                     limited;
        logic                     floored;
    } force_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wen;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_W-1:0]       i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_W-1:0]      o_m_axis_tdata;

    clamped_gravity_force #(.COORD_WIDTH(CW)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wen(i_cfg_wen), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata)
    );

    class force_board;
        logic [GRAV_W-1:0]  grav;
        logic [MINS_W-1:0]  min_sep;
        logic [FORCE_W-1:0] max_f;
        force_t             pending[$];
        int                 errors;

        function new();
            grav = GRAV_RESET;
            min_sep = MINS_RESET;
            max_f = MAXF_RESET;
            errors = 0;
        endfunction

        function automatic logic [33:0] int_sqrt(logic [127:0] x);
            logic [33:0] r;
            logic [33:0] c;
            r = '0;
            for (int b = 33; b >= 0; b--) begin
                c = r | (34'd1 << b);
                if ({94'd0, c} * {94'd0, c} <= x) r = c;
            end
            return r;
        endfunction

        function automatic void note_pair(logic [IN_W-1:0] w);
            logic signed [CW-1:0] sx, sy, ox, oy;
            logic [MASS_W-1:0]    m1, m2;
            logic signed [63:0]   dx, dy;
            logic [63:0]          adx, ady, f, root_len, cx, cy;
            logic [127:0]         d2, minsq, eff, num, den;
            force_t               r;
            {m2, m1, oy, ox, sy, sx} = w[4*CW+2*MASS_W-1:0];
            dx = 64'(ox) - 64'(sx);
            dy = 64'(oy) - 64'(sy);
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            d2 = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
            minsq = 128'(min_sep) * 128'(min_sep);
            r = '0;
            eff = d2;
            if (d2 < minsq) begin
                eff = minsq;
                r.floored = 1'b1;
            end
            if (d2 != 0) begin
                num = 128'(grav) * 128'(m1) * 128'(m2);
                den = eff << 8;
                if (num >= (den << 24)) begin
                    f = 64'(max_f);
                    r.limited = 1'b1;
                end else begin
                    f = 64'(num / den);
                    if (f > 64'(max_f)) begin
                        f = 64'(max_f);
                        r.limited = 1'b1;
                    end
                end
                root_len = 64'(int_sqrt(d2));
                cx = (f * adx) / root_len;
                cy = (f * ady) / root_len;
                r.fx = dx < 0 ? -OUTC_W'(cx) : OUTC_W'(cx);
                r.fy = dy < 0 ? -OUTC_W'(cy) : OUTC_W'(cy);
            end
            pending.push_back(r);
        endfunction

        function automatic void check_force(logic [OUT_W-1:0] w);
            force_t got, want;
            got.fx = w[OUTC_W-1:0];
            got.fy = w[2*OUTC_W-1:OUTC_W];
            got.limited = w[2*OUTC_W];
            got.floored = w[2*OUTC_W+1];
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h", $time, w);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.fx !== want.fx)
                $display("%0t: force_x expected %0d got %0d", $time, want.fx, got.fx);
            if (got.fy !== want.fy)
                $display("%0t: force_y expected %0d got %0d", $time, want.fy, got.fy);
            if (got.limited !== want.limited)
                $display("%0t: was_limited expected %0b got %0b", $time,
                         want.limited, got.limited);
            if (got.floored !== want.floored)
                $display("%0t: was_floored expected %0b got %0b", $time,
                         want.floored, got.floored);
            if (got !== want) errors++;
        endfunction
    endclass

    force_board board;
    int         idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) board.check_force(o_m_axis_tdata);
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WD_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int gap;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            repeat (gap) @(posedge i_clk);
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_axis_tvalid) @(posedge i_clk);
            if ($urandom_range(0, 1) == 0) i_m_axis_tready <= 1'b0;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_wen <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        case (idx)
            CFG_GRAV_CONST: board.grav = val;
            CFG_MIN_SEP:    board.min_sep = val[MINS_W-1:0];
            CFG_MAX_FORCE:  board.max_f = val[FORCE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_pair(logic [CW-1:0] sx, logic [CW-1:0] sy, logic [CW-1:0] ox,
                             logic [CW-1:0] oy, logic [MASS_W-1:0] m1,
                             logic [MASS_W-1:0] m2, bit bursty);
        logic [IN_W-1:0] w;
        int gap;
        w = '0;
        w[4*CW+2*MASS_W-1:0] = {m2, m1, oy, ox, sy, sx};
        gap = bursty ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= w;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        board.note_pair(w);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    function automatic logic [CW-1:0] rand_coord(int mode);
        case (mode)
            0: return CW'($urandom_range(0, 4000)) - CW'(2000);
            1: return CW'($urandom);
            default: return CW'($urandom_range(0, 1)) ? {1'b1, {(CW-1){1'b0}}}
                                                      : {1'b0, {(CW-1){1'b1}}};
        endcase
    endfunction

    function automatic logic [MASS_W-1:0] rand_mass();
        case ($urandom_range(0, 3))
            0: return MASS_W'($urandom);
            1: return MASS_W'($urandom_range(0, 4096));
            2: return {MASS_W{1'b1}};
            default: return MASS_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_pairs(int n);
        logic [CW-1:0] sx, sy;
        bit bursty;
        int mode;
        for (int k = 0; k < n; k++) begin
            bursty = ((k / 64) % 3) == 0;
            mode = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 9) < 8 ? 1 : 2);
            sx = rand_coord(mode);
            sy = rand_coord(mode);
            if ($urandom_range(0, 19) == 0)
                send_pair(sx, sy, sx, sy, rand_mass(), rand_mass(), bursty);
            else
                send_pair(sx, sy, sx + rand_coord(0), sy + rand_coord(0),
                          rand_mass(), rand_mass(), bursty);
        end
    endtask

    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [MASS_W-1:0] MONE = 24'd256;
    localparam logic [MASS_W-1:0] MMAX = 24'hFFFFFF;

    initial begin
        board = new();
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_wen = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pair(0, 0, 0, 0, MONE, MONE, 0);
        send_pair(0, 0, 24'd256, 0, MONE, MONE, 0);
        send_pair(0, 0, 0, -24'd5000, MONE, MONE, 0);
        send_pair(0, 0, 24'd3000, 24'd4000, MONE, MONE, 0);
        send_pair(CMIN, CMIN, CMAX, CMAX, MMAX, MMAX, 0);
        send_pair(CMAX, CMAX, CMIN, CMIN, MONE, MONE, 0);
        send_pair(CMAX, 0, CMIN, 0, 0, MMAX, 0);
        send_pair(0, CMIN, 0, CMAX, MMAX, 0, 0);
        send_pair(24'd100, 24'd100, -24'd100, 24'd100, MMAX, MMAX, 0);
        send_pair(24'd5, -24'd7, 24'd2560, 24'd1, MMAX, 24'd1, 0);
        send_pair(24'd1, 24'd1, 24'd1, 24'd1, MMAX, MMAX, 0);
        send_pair(0, 0, 24'd2560, 0, 24'd2560, 24'd2560, 0);
        random_pairs(200);
        drain();

        write_reg(CFG_GRAV_CONST, 32'hFFFFFFFF);
        write_reg(CFG_MIN_SEP, 32'd1);
        write_reg(CFG_MAX_FORCE, 32'hFFFFFF);
        send_pair(0, 0, 24'd1, 0, MMAX, MMAX, 0);
        send_pair(0, 0, 0, 0, MMAX, MMAX, 0);
        random_pairs(350);
        drain();

        write_reg(CFG_GRAV_CONST, 32'd0);
        write_reg(CFG_MIN_SEP, 32'hFFFF);
        write_reg(CFG_MAX_FORCE, 32'd0);
        random_pairs(200);
        drain();

        write_reg(CFG_GRAV_CONST, 32'd65536);
        write_reg(CFG_MIN_SEP, 32'd256);
        write_reg(CFG_MAX_FORCE, 32'd256000);
        random_pairs(350);
        drain();

        for (int p = 0; p < 4; p++) begin
            write_reg(CFG_GRAV_CONST, $urandom);
            write_reg(CFG_MIN_SEP, $urandom_range(1, 65535));
            write_reg(CFG_MAX_FORCE, $urandom_range(0, 16777215));
            random_pairs(NRAND / 11);
            drain();
        end

        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire
